// ----- design/ttsb_pkg.sv -----
// ----------------------------------------------------------------------------
// Text terminal screen buffer package
// Shared widths, command codes, character codes and the structs that travel
// between the command front end and the executor.
// ----------------------------------------------------------------------------
package ttsb_pkg;

  localparam int FUNC_W       = 3;
  localparam int CHAR_W       = 8;
  localparam int COORD_W      = 8;
  localparam int CURSOR_COL_W = 7;
  localparam int CURSOR_ROW_W = 5;
  localparam int CFG_ADDR_W   = 3;
  localparam int CFG_DATA_W   = 32;
  localparam int QUEUE_DEPTH  = 2;

  // Register index, taken from the word address bits of paddr.
  localparam logic [CFG_ADDR_W-3:0] CFG_IDX_AUTOWRAP = '0;

  // Command codes on the func field.
  localparam logic [FUNC_W-1:0] FUNC_PUT_CHAR     = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR_SCREEN = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR_EOL    = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_GOTO_XY      = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_READ_CELL    = 3'd4;

  // Character codes with a meaning of their own.
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_CR    = 8'd13;
  localparam logic [CHAR_W-1:0] CHAR_LF    = 8'd10;
  localparam logic [CHAR_W-1:0] CHAR_BS    = 8'd8;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_PRINT,
    OP_CR,
    OP_LF,
    OP_BS,
    OP_CLR_SCREEN,
    OP_CLR_EOL,
    OP_GOTO,
    OP_READ
  } op_kind_t;

  // A classified command. col and row are already 0-based.
  typedef struct packed {
    op_kind_t            kind;
    logic [CHAR_W-1:0]   ch;
    logic                col_ok;
    logic                row_ok;
    logic [COORD_W-1:0]  col;
    logic [COORD_W-1:0]  row;
  } op_t;

  typedef struct packed {
    logic valid;
    op_t  op;
  } queue_head_t;

  typedef struct packed {
    logic init_busy;
  } back_status_t;

  typedef struct packed {
    logic [CHAR_W-1:0]       cell_char;
    logic [CURSOR_COL_W-1:0] cursor_col;
    logic [CURSOR_ROW_W-1:0] cursor_row;
    logic                    scrolled;
  } res_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLR_ALL,
    ST_SWEEP_ROW,
    ST_READ
  } back_state_t;

endpackage

// ----- design/ttsb_ram.sv -----
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module ttsb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- design/ttsb_fifo.sv -----
// ----------------------------------------------------------------------------
// Small register FIFO
// Flop-based queue used between the front end and the executor and on the
// result side.
// ----------------------------------------------------------------------------
module ttsb_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             push_ok;
  logic             pop_ok;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign push_ok = push && !full;
  assign pop_ok  = pop && !empty;
  assign dout    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push_ok) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_r + 1'b1);
    end
    if (pop_ok) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_r + 1'b1);
    end
    if (push_ok && !pop_ok) begin
      count_nxt = CNT_W'(count_r + 1'b1);
    end else if (pop_ok && !push_ok) begin
      count_nxt = CNT_W'(count_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

endmodule

// ----- design/ttsb_front.sv -----
// ----------------------------------------------------------------------------
// Text terminal command front end
// Accepts command transactions, decodes them into executor operations with
// range-checked 0-based coordinates, and queues them for the executor.
// ----------------------------------------------------------------------------
module ttsb_front #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 30
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  output logic                          full,
  input  logic [ttsb_pkg::FUNC_W-1:0]   func,
  input  logic [ttsb_pkg::CHAR_W-1:0]   char_code,
  input  logic [ttsb_pkg::COORD_W-1:0]  target_col,
  input  logic [ttsb_pkg::COORD_W-1:0]  target_row,
  input  ttsb_pkg::back_status_t        status,
  output ttsb_pkg::queue_head_t         head,
  input  logic                          op_pop
);

  localparam int OP_W = $bits(ttsb_pkg::op_t);

  ttsb_pkg::op_t   op_d;
  logic [OP_W-1:0] op_q;
  logic            q_full;
  logic            q_empty;

  always_comb begin
    op_d.ch     = char_code;
    op_d.col_ok = (target_col != '0) &&
                  (target_col <= ttsb_pkg::COORD_W'(COLUMNS));
    op_d.row_ok = (target_row != '0) &&
                  (target_row <= ttsb_pkg::COORD_W'(ROWS));
    op_d.col    = ttsb_pkg::COORD_W'(target_col - 1'b1);
    op_d.row    = ttsb_pkg::COORD_W'(target_row - 1'b1);
    unique case (func)
      ttsb_pkg::FUNC_PUT_CHAR: begin
        unique case (char_code)
          ttsb_pkg::CHAR_CR: op_d.kind = ttsb_pkg::OP_CR;
          ttsb_pkg::CHAR_LF: op_d.kind = ttsb_pkg::OP_LF;
          ttsb_pkg::CHAR_BS: op_d.kind = ttsb_pkg::OP_BS;
          default:           op_d.kind = ttsb_pkg::OP_PRINT;
        endcase
      end
      ttsb_pkg::FUNC_CLEAR_SCREEN: op_d.kind = ttsb_pkg::OP_CLR_SCREEN;
      ttsb_pkg::FUNC_CLEAR_EOL:    op_d.kind = ttsb_pkg::OP_CLR_EOL;
      ttsb_pkg::FUNC_GOTO_XY:      op_d.kind = ttsb_pkg::OP_GOTO;
      ttsb_pkg::FUNC_READ_CELL:    op_d.kind = ttsb_pkg::OP_READ;
      default:                     op_d.kind = ttsb_pkg::OP_NOP;
    endcase
  end

  // No commands are taken while the cell store is being cleared after reset.
  assign full = q_full || status.init_busy;

  ttsb_fifo #(
    .WIDTH(OP_W),
    .DEPTH(ttsb_pkg::QUEUE_DEPTH)
  ) u_cmd_q (
    .clk  (clk),
    .rst_n(rst_n),
    .push (push && !full),
    .din  (op_d),
    .full (q_full),
    .pop  (op_pop),
    .dout (op_q),
    .empty(q_empty)
  );

  assign head.valid = !q_empty;
  assign head.op    = ttsb_pkg::op_t'(op_q);

endmodule

// ----- design/ttsb_back.sv -----
// ----------------------------------------------------------------------------
// Text terminal executor
// Holds the cursor and the cell store, runs one operation at a time and
// queues one result per operation. Scrolling rotates a top-row pointer and
// clears one line instead of moving the whole store.
// ----------------------------------------------------------------------------
module ttsb_back #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 30
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   autowrap,
  input  ttsb_pkg::queue_head_t  head,
  output logic                   op_pop,
  output ttsb_pkg::back_status_t status,
  input  logic                   pop,
  output logic                   empty,
  output ttsb_pkg::res_t         res
);

  localparam int CELLS  = ROWS * COLUMNS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int COL_W  = $clog2(COLUMNS + 1);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int RES_W  = $bits(ttsb_pkg::res_t);

  ttsb_pkg::back_state_t state_r, state_nxt;
  logic [COL_W-1:0]  cur_col_r, cur_col_nxt;
  logic [ROW_W-1:0]  cur_row_r, cur_row_nxt;
  logic [ROW_W-1:0]  top_r, top_nxt;
  logic [ADDR_W-1:0] top_base_r, top_base_nxt;
  logic [ADDR_W-1:0] sw_addr_r, sw_addr_nxt;
  logic [COL_W-1:0]  sw_col_r, sw_col_nxt;
  logic              scr_r, scr_nxt;

  logic                        we;
  logic [ADDR_W-1:0]           waddr;
  logic [ttsb_pkg::CHAR_W-1:0] wdata;
  logic                        re;
  logic [ADDR_W-1:0]           raddr;
  logic [ttsb_pkg::CHAR_W-1:0] rdata;

  logic                        res_push;
  logic                        res_full;
  logic [ttsb_pkg::CHAR_W-1:0] res_cell;
  logic                        res_scr;
  ttsb_pkg::res_t              res_d;
  logic [RES_W-1:0]            res_q;

  logic              parked;
  logic              new_line;
  logic [COL_W-1:0]  col_inc;
  logic [ADDR_W-1:0] addr_cur;
  logic              sweep_last;

  // Logical row to physical cell address, through the rotating top row.
  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                  input logic [ROW_W-1:0] top,
                                                  input logic [COL_W-1:0] col);
    logic [ROW_W:0]   sum;
    logic [ROW_W-1:0] phys;
    sum = {1'b0, row} + {1'b0, top};
    if (sum >= (ROW_W + 1)'(ROWS)) begin
      phys = ROW_W'(sum - (ROW_W + 1)'(ROWS));
    end else begin
      phys = ROW_W'(sum);
    end
    return ADDR_W'(ADDR_W'(phys) * ADDR_W'(COLUMNS) + ADDR_W'(col));
  endfunction

  assign parked     = (cur_col_r == COL_W'(COLUMNS));
  assign col_inc    = COL_W'(cur_col_r + 1'b1);
  assign addr_cur   = cell_addr(cur_row_r, top_r, cur_col_r);
  assign raddr      = cell_addr(ROW_W'(head.op.row), top_r, COL_W'(head.op.col));
  assign sweep_last = (sw_addr_r == ADDR_W'(CELLS - 1));
  assign status.init_busy = (state_r == ttsb_pkg::ST_INIT);

  always_comb begin
    state_nxt    = state_r;
    cur_col_nxt  = cur_col_r;
    cur_row_nxt  = cur_row_r;
    top_nxt      = top_r;
    top_base_nxt = top_base_r;
    sw_addr_nxt  = sw_addr_r;
    sw_col_nxt   = sw_col_r;
    scr_nxt      = scr_r;
    we           = 1'b0;
    waddr        = sw_addr_r;
    wdata        = ttsb_pkg::CHAR_SPACE;
    re           = 1'b0;
    op_pop       = 1'b0;
    res_push     = 1'b0;
    res_cell     = ttsb_pkg::CHAR_SPACE;
    res_scr      = 1'b0;
    new_line     = 1'b0;

    unique case (state_r)
      ttsb_pkg::ST_INIT: begin
        we = 1'b1;
        if (sweep_last) begin
          sw_addr_nxt = '0;
          state_nxt   = ttsb_pkg::ST_IDLE;
        end else begin
          sw_addr_nxt = ADDR_W'(sw_addr_r + 1'b1);
        end
      end

      ttsb_pkg::ST_CLR_ALL: begin
        we = 1'b1;
        if (sweep_last) begin
          sw_addr_nxt = '0;
          res_push    = 1'b1;
          state_nxt   = ttsb_pkg::ST_IDLE;
        end else begin
          sw_addr_nxt = ADDR_W'(sw_addr_r + 1'b1);
        end
      end

      ttsb_pkg::ST_SWEEP_ROW: begin
        we = 1'b1;
        if (sw_col_r == COL_W'(COLUMNS - 1)) begin
          res_push  = 1'b1;
          res_scr   = scr_r;
          state_nxt = ttsb_pkg::ST_IDLE;
        end else begin
          sw_addr_nxt = ADDR_W'(sw_addr_r + 1'b1);
          sw_col_nxt  = COL_W'(sw_col_r + 1'b1);
        end
      end

      ttsb_pkg::ST_READ: begin
        res_push  = 1'b1;
        res_cell  = rdata;
        state_nxt = ttsb_pkg::ST_IDLE;
      end

      ttsb_pkg::ST_IDLE: begin
        if (head.valid && !res_full) begin
          op_pop = 1'b1;
          unique case (head.op.kind)
            ttsb_pkg::OP_PRINT: begin
              if (!parked) begin
                we    = 1'b1;
                waddr = addr_cur;
                wdata = head.op.ch;
                if (col_inc == COL_W'(COLUMNS) && autowrap) begin
                  new_line = 1'b1;
                end else begin
                  cur_col_nxt = col_inc;
                end
              end
            end
            ttsb_pkg::OP_CR: begin
              if (!parked) begin
                cur_col_nxt = '0;
              end
            end
            ttsb_pkg::OP_LF: begin
              if (!parked) begin
                new_line = 1'b1;
              end
            end
            ttsb_pkg::OP_BS: begin
              if (!parked && cur_col_r != '0) begin
                we          = 1'b1;
                waddr       = ADDR_W'(addr_cur - 1'b1);
                cur_col_nxt = COL_W'(cur_col_r - 1'b1);
              end
            end
            ttsb_pkg::OP_CLR_SCREEN: begin
              cur_col_nxt  = '0;
              cur_row_nxt  = '0;
              top_nxt      = '0;
              top_base_nxt = '0;
              sw_addr_nxt  = '0;
              state_nxt    = ttsb_pkg::ST_CLR_ALL;
            end
            ttsb_pkg::OP_CLR_EOL: begin
              if (!parked) begin
                sw_addr_nxt = addr_cur;
                sw_col_nxt  = cur_col_r;
                scr_nxt     = 1'b0;
                state_nxt   = ttsb_pkg::ST_SWEEP_ROW;
              end
            end
            ttsb_pkg::OP_GOTO: begin
              if (head.op.col_ok) begin
                cur_col_nxt = COL_W'(head.op.col);
              end
              if (head.op.row_ok) begin
                cur_row_nxt = ROW_W'(head.op.row);
              end
            end
            ttsb_pkg::OP_READ: begin
              if (head.op.col_ok && head.op.row_ok) begin
                re        = 1'b1;
                state_nxt = ttsb_pkg::ST_READ;
              end
            end
            ttsb_pkg::OP_NOP: begin
            end
            default: begin
            end
          endcase

          if (new_line) begin
            cur_col_nxt = '0;
            if (cur_row_r == ROW_W'(ROWS - 1)) begin
              // The old top line becomes the new bottom line and is blanked.
              top_nxt      = (top_r == ROW_W'(ROWS - 1)) ? '0 : ROW_W'(top_r + 1'b1);
              top_base_nxt = (top_r == ROW_W'(ROWS - 1)) ? '0 :
                             ADDR_W'(top_base_r + ADDR_W'(COLUMNS));
              sw_addr_nxt  = top_base_r;
              sw_col_nxt   = '0;
              scr_nxt      = 1'b1;
              state_nxt    = ttsb_pkg::ST_SWEEP_ROW;
            end else begin
              cur_row_nxt = ROW_W'(cur_row_r + 1'b1);
            end
          end

          if (state_nxt == ttsb_pkg::ST_IDLE) begin
            res_push = 1'b1;
          end
        end
      end

      default: begin
        state_nxt = ttsb_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ttsb_pkg::ST_INIT;
      cur_col_r  <= '0;
      cur_row_r  <= '0;
      top_r      <= '0;
      top_base_r <= '0;
      sw_addr_r  <= '0;
      sw_col_r   <= '0;
      scr_r      <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      cur_col_r  <= cur_col_nxt;
      cur_row_r  <= cur_row_nxt;
      top_r      <= top_nxt;
      top_base_r <= top_base_nxt;
      sw_addr_r  <= sw_addr_nxt;
      sw_col_r   <= sw_col_nxt;
      scr_r      <= scr_nxt;
    end
  end

  ttsb_ram #(
    .WIDTH(ttsb_pkg::CHAR_W),
    .DEPTH(CELLS)
  ) u_cells (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (re),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign res_d.cell_char  = res_cell;
  assign res_d.cursor_col = ttsb_pkg::CURSOR_COL_W'(cur_col_nxt);
  assign res_d.cursor_row = ttsb_pkg::CURSOR_ROW_W'(cur_row_nxt);
  assign res_d.scrolled   = res_scr;

  ttsb_fifo #(
    .WIDTH(RES_W),
    .DEPTH(ttsb_pkg::QUEUE_DEPTH)
  ) u_res_q (
    .clk  (clk),
    .rst_n(rst_n),
    .push (res_push),
    .din  (res_d),
    .full (res_full),
    .pop  (pop),
    .dout (res_q),
    .empty(empty)
  );

  assign res = ttsb_pkg::res_t'(res_q);

  a_no_result_in_init: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ttsb_pkg::ST_INIT) |-> !res_push)
    else $error("result produced during the reset clearing pass");

  a_read_returns: assert property (@(posedge clk) disable iff (!rst_n)
    re |=> (state_r == ttsb_pkg::ST_READ && res_push))
    else $error("cell read did not return a result on the next cycle");

  a_pop_when_ready: assert property (@(posedge clk) disable iff (!rst_n)
    op_pop |-> (state_r == ttsb_pkg::ST_IDLE && !res_full))
    else $error("operation taken while executor busy or result queue full");

  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cur_row_r <= ROW_W'(ROWS - 1)) && (top_r <= ROW_W'(ROWS - 1)) &&
    (cur_col_r <= COL_W'(COLUMNS)))
    else $error("cursor or top row out of range");

endmodule

// ----- design/text_terminal_screen_buffer.sv -----
// ----------------------------------------------------------------------------
// Text terminal screen buffer
// Character-cell screen store with a cursor, fed by command transactions.
// ----------------------------------------------------------------------------
// The block keeps ROWS lines of COLUMNS 8-bit character cells and a cursor,
// and returns exactly one result transaction (read cell, cursor position,
// scroll flag) for every command transaction in the order received. After
// reset the cell store is filled with spaces by a clearing pass, during
// which full stays high. Timing is set by the single write port of the cell
// store: characters, carriage return, line feed without scroll, backspace,
// goto and unused codes are handled without leaving the idle state, so they
// stream at one per cycle while the result queue has room; read_cell waits
// for the registered read data; clear_eol blanks the cells from the cursor
// to the end of the line one by one; a scroll (line feed on the bottom line
// or autowrap past it) also blanks the new bottom line; clear_screen blanks
// every cell. At the earliest, empty falls once the command has passed
// through the command queue and the executor into the result queue.
// ----------------------------------------------------------------------------
module text_terminal_screen_buffer #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 30
) (
  input  logic                               clk,
  input  logic                               rst_n,

  // Command channel.
  input  logic                               push,
  output logic                               full,
  input  logic [ttsb_pkg::FUNC_W-1:0]        in_func,
  input  logic [ttsb_pkg::CHAR_W-1:0]        in_char_code,
  input  logic [ttsb_pkg::COORD_W-1:0]       in_target_col,
  input  logic [ttsb_pkg::COORD_W-1:0]       in_target_row,

  // Result channel.
  output logic                               empty,
  input  logic                               pop,
  output logic [ttsb_pkg::CHAR_W-1:0]        out_cell_char,
  output logic [ttsb_pkg::CURSOR_COL_W-1:0]  out_cursor_col,
  output logic [ttsb_pkg::CURSOR_ROW_W-1:0]  out_cursor_row,
  output logic                               out_scrolled,

  // Configuration port.
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [ttsb_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [ttsb_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [ttsb_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                               pready
);

  logic                   autowrap_r;
  logic                   cfg_wr;
  logic                   cfg_hit;
  ttsb_pkg::queue_head_t  head;
  ttsb_pkg::back_status_t status;
  ttsb_pkg::res_t         res;
  logic                   op_pop;

  // The register file is a single bit; the word index sits above the byte
  // offset in paddr, and other indexes read as zero and ignore writes.
  assign pready  = 1'b1;
  assign cfg_hit = (paddr[ttsb_pkg::CFG_ADDR_W-1:2] == ttsb_pkg::CFG_IDX_AUTOWRAP);
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign prdata  = cfg_hit ? ttsb_pkg::CFG_DATA_W'(autowrap_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      autowrap_r <= 1'b0;
    end else if (cfg_wr && cfg_hit) begin
      autowrap_r <= pwdata[0];
    end
  end

  // The front end decodes each command transaction and queues it, so that up
  // to two simple commands can still be taken while the executor is busy.
  ttsb_front #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .func      (in_func),
    .char_code (in_char_code),
    .target_col(in_target_col),
    .target_row(in_target_row),
    .status    (status),
    .head      (head),
    .op_pop    (op_pop)
  );

  // The executor owns the cursor, the cell store and the result queue.
  ttsb_back #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .autowrap(autowrap_r),
    .head    (head),
    .op_pop  (op_pop),
    .status  (status),
    .pop     (pop),
    .empty   (empty),
    .res     (res)
  );

  assign out_cell_char  = res.cell_char;
  assign out_cursor_col = res.cursor_col;
  assign out_cursor_row = res.cursor_row;
  assign out_scrolled   = res.scrolled;

endmodule

// ----- verif/tb_top.sv -----
// ----------------------------------------------------------------------------
// Text terminal screen buffer testbench
// Drives command transactions into the screen buffer through its push/full
// side, predicts every result from a private copy of the screen and cursor,
// and checks each popped result field by field, with random idling on both
// sides and the autowrap register toggled between phases.
// ----------------------------------------------------------------------------
module tb_top;
  import ttsb_pkg::*;

  localparam int COLUMNS      = 80;
  localparam int ROWS         = 30;
  localparam int CELLS        = COLUMNS * ROWS;
  localparam int PHASE_ITEMS  = 150;
  localparam int DRAIN_CYCLES = 50;
  localparam int STALL_CYCLES = 400;

  // One command transaction as it sits on the input ports.
  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [CHAR_W-1:0]  ch;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
  } term_cmd_t;

  // Every input of the block starts at a known value.
  logic                    clk     = 1'b0;
  logic                    rst_n   = 1'b0;
  logic                    push    = 1'b0;
  logic [FUNC_W-1:0]       in_func       = '0;
  logic [CHAR_W-1:0]       in_char_code  = '0;
  logic [COORD_W-1:0]      in_target_col = '0;
  logic [COORD_W-1:0]      in_target_row = '0;
  logic                    pop     = 1'b0;
  logic                    psel    = 1'b0;
  logic                    penable = 1'b0;
  logic                    pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0]   paddr   = '0;
  logic [CFG_DATA_W-1:0]   pwdata  = '0;

  logic                    full;
  logic                    empty;
  logic [CHAR_W-1:0]       out_cell_char;
  logic [CURSOR_COL_W-1:0] out_cursor_col;
  logic [CURSOR_ROW_W-1:0] out_cursor_row;
  logic                    out_scrolled;
  logic [CFG_DATA_W-1:0]   prdata;
  logic                    pready;

  text_terminal_screen_buffer #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (push),
    .full          (full),
    .in_func       (in_func),
    .in_char_code  (in_char_code),
    .in_target_col (in_target_col),
    .in_target_row (in_target_row),
    .empty         (empty),
    .pop           (pop),
    .out_cell_char (out_cell_char),
    .out_cursor_col(out_cursor_col),
    .out_cursor_row(out_cursor_row),
    .out_scrolled  (out_scrolled),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #10 clk = ~clk;

  // Commands waiting to be offered, and the results they are predicted to give.
  term_cmd_t pending_cmds[$];
  res_t      expected_results[$];
  term_cmd_t offered_cmd;
  int        accepted_total = 0;
  int        error_count    = 0;

  // Idling controls. The idle and stall flags are changed only with nonblocking
  // assignments so that the clocked driver and monitor never race with the stimulus process.
  bit        tx_idle  = 1'b0;
  bit        rx_idle  = 1'b0;
  bit        rx_stall = 1'b0;
  int        tx_gap   = 0;
  int        rx_gap   = 0;

  // Private copy of the screen, the cursor and the autowrap register.
  logic [CHAR_W-1:0] screen_model [0:CELLS-1];
  int                cur_col_model = 0;
  int                cur_row_model = 0;
  bit                autowrap_model = 1'b0;

  initial begin
    for (int i = 0; i < CELLS; i++) screen_model[i] = CHAR_SPACE;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    error_count++;
  endtask

  // Gap lengths: mostly none or short, now and then a long one.
  function automatic int pick_gap(input bit idle_on);
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Carriage to column 0 of the next line; at the bottom the whole screen
  // moves up one line and the new bottom line is blank.
  task automatic advance_line(output bit scrolled);
    scrolled = 1'b0;
    cur_col_model = 0;
    cur_row_model++;
    if (cur_row_model >= ROWS) begin
      cur_row_model = ROWS - 1;
      for (int i = 0; i < (ROWS - 1) * COLUMNS; i++) screen_model[i] = screen_model[i + COLUMNS];
      for (int i = (ROWS - 1) * COLUMNS; i < CELLS; i++) screen_model[i] = CHAR_SPACE;
      scrolled = 1'b1;
    end
  endtask

  // Applies one accepted command to the private copy and returns the result
  // the block must give for it.
  task automatic predict_command(input term_cmd_t c, output res_t r);
    int pos;
    bit scr;
    scr = 1'b0;
    r.cell_char = CHAR_SPACE;
    case (c.func)
      FUNC_PUT_CHAR: begin
        // A parked cursor (column equal to COLUMNS) ignores every character.
        if (cur_col_model < COLUMNS) begin
          pos = cur_row_model * COLUMNS + cur_col_model;
          if (c.ch == CHAR_CR) begin
            cur_col_model = 0;
          end else if (c.ch == CHAR_LF) begin
            advance_line(scr);
          end else if (c.ch == CHAR_BS) begin
            if (cur_col_model > 0) begin
              cur_col_model--;
              screen_model[pos - 1] = CHAR_SPACE;
            end
          end else begin
            screen_model[pos] = c.ch;
            cur_col_model++;
            if (cur_col_model >= COLUMNS && autowrap_model) advance_line(scr);
          end
        end
      end
      FUNC_CLEAR_SCREEN: begin
        for (int i = 0; i < CELLS; i++) screen_model[i] = CHAR_SPACE;
        cur_col_model = 0;
        cur_row_model = 0;
      end
      FUNC_CLEAR_EOL: begin
        for (int i = cur_col_model; i < COLUMNS; i++)
          screen_model[cur_row_model * COLUMNS + i] = CHAR_SPACE;
      end
      FUNC_GOTO_XY: begin
        // Each axis moves on its own; an out-of-range axis stays put.
        if (c.col >= 1 && c.col <= COLUMNS) cur_col_model = c.col - 1;
        if (c.row >= 1 && c.row <= ROWS) cur_row_model = c.row - 1;
      end
      FUNC_READ_CELL: begin
        if (c.col >= 1 && c.col <= COLUMNS && c.row >= 1 && c.row <= ROWS)
          r.cell_char = screen_model[(c.row - 1) * COLUMNS + (c.col - 1)];
      end
      default: begin
        // Unused command codes change nothing.
      end
    endcase
    r.cursor_col = cur_col_model[CURSOR_COL_W-1:0];
    r.cursor_row = cur_row_model[CURSOR_ROW_W-1:0];
    r.scrolled   = scr;
  endtask

  // Driver: offers queued commands, holds a command while full is high, and
  // predicts each command at the edge where its transaction completes.
  always @(posedge clk) begin
    res_t want;
    if (push && !full) begin
      predict_command(offered_cmd, want);
      expected_results.push_back(want);
      accepted_total++;
      tx_gap = pick_gap(tx_idle);
    end
    if (push && full) begin
      // The offered command stays on the ports until it is taken.
    end else if (tx_gap > 0) begin
      tx_gap--;
      push <= 1'b0;
    end else if (pending_cmds.size() > 0) begin
      offered_cmd = pending_cmds.pop_front();
      in_func       <= offered_cmd.func;
      in_char_code  <= offered_cmd.ch;
      in_target_col <= offered_cmd.col;
      in_target_row <= offered_cmd.row;
      push <= 1'b1;
    end else begin
      push <= 1'b0;
    end
  end

  // Monitor: pops results with random gaps and compares each one with the
  // oldest prediction.
  always @(posedge clk) begin
    res_t want;
    if (pop && !empty) begin
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("result with no command outstanding (col %0d row %0d)",
                                  out_cursor_col, out_cursor_row));
      end else begin
        want = expected_results.pop_front();
        if (out_cell_char !== want.cell_char)
          report_mismatch($sformatf("cell_char got %0d expected %0d",
                                    out_cell_char, want.cell_char));
        if (out_cursor_col !== want.cursor_col)
          report_mismatch($sformatf("cursor_col got %0d expected %0d",
                                    out_cursor_col, want.cursor_col));
        if (out_cursor_row !== want.cursor_row)
          report_mismatch($sformatf("cursor_row got %0d expected %0d",
                                    out_cursor_row, want.cursor_row));
        if (out_scrolled !== want.scrolled)
          report_mismatch($sformatf("scrolled got %0d expected %0d",
                                    out_scrolled, want.scrolled));
      end
      rx_gap = pick_gap(rx_idle);
    end else if (rx_gap > 0) begin
      rx_gap--;
    end
    pop <= !rx_stall && (rx_gap == 0);
  end

  // Once the run is well under way the receiver stops popping for a long
  // stretch while the sender keeps offering, so the block fills and raises
  // full.
  initial begin
    do @(negedge clk); while (accepted_total < 2 * PHASE_ITEMS);
    @(posedge clk);
    rx_stall <= 1'b1;
    repeat (STALL_CYCLES) @(posedge clk);
    rx_stall <= 1'b0;
  end

  // Global time limit, far above the slowest correct run.
  initial begin
    #(20 * 1000000);
    $display("status: fail");
    $finish;
  end

  task automatic queue_cmd(input logic [FUNC_W-1:0] func, input int ch, input int col,
                           input int row);
    term_cmd_t c;
    c.func = func;
    c.ch   = ch[CHAR_W-1:0];
    c.col  = col[COORD_W-1:0];
    c.row  = row[COORD_W-1:0];
    pending_cmds.push_back(c);
  endtask

  // Waits until every queued command has been taken and every predicted
  // result has come back, then lets the block settle.
  task automatic wait_drained();
    do @(negedge clk); while (pending_cmds.size() != 0 || push || expected_results.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Writes the autowrap register through the configuration port and reads
  // it back. The write lands at the access edge with pready high.
  task automatic set_autowrap(input bit value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {CFG_IDX_AUTOWRAP, 2'b00};
    pwdata  <= CFG_DATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    autowrap_model = value;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== CFG_DATA_W'(value))
      report_mismatch($sformatf("autowrap read back %0h expected %0h", prdata, value));
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  // One random command. Every field carries random bits; the mix leans on
  // characters and in-range cursor moves and reads, with rare screen clears
  // since each one walks the whole store.
  function automatic term_cmd_t random_cmd();
    term_cmd_t c;
    int pick;
    c.ch  = CHAR_W'($urandom);
    c.col = COORD_W'($urandom);
    c.row = COORD_W'($urandom);
    pick = $urandom_range(199);
    if (pick < 80) begin
      c.func = FUNC_PUT_CHAR;
    end else if (pick < 100) begin
      c.func = FUNC_PUT_CHAR;
      case ($urandom_range(2))
        0:       c.ch = CHAR_CR;
        1:       c.ch = CHAR_LF;
        default: c.ch = CHAR_BS;
      endcase
    end else if (pick < 130) begin
      c.func = FUNC_GOTO_XY;
      if (pick < 120) begin
        c.col = COORD_W'($urandom_range(1, COLUMNS));
        c.row = COORD_W'(($urandom_range(2) == 0) ? ROWS : $urandom_range(1, ROWS));
      end
    end else if (pick < 170) begin
      c.func = FUNC_READ_CELL;
      if (pick < 160) begin
        c.col = COORD_W'($urandom_range(1, COLUMNS));
        c.row = COORD_W'($urandom_range(1, ROWS));
      end
    end else if (pick < 182) begin
      c.func = FUNC_CLEAR_EOL;
    end else if (pick < 183) begin
      c.func = FUNC_CLEAR_SCREEN;
    end else begin
      c.func = FUNC_W'($urandom_range(5, 7));
    end
    return c;
  endfunction

  // Fills the command queue for one random phase. Most of it is text runs
  // and write-then-read probes, which keep the cursor moving across the
  // screen, into the last column and over the bottom line; the rest is
  // single random commands.
  task automatic queue_random_phase(input int n, input bit idle_on);
    int made;
    int len;
    int x;
    int y;
    tx_idle <= idle_on;
    rx_idle <= idle_on;
    made = 0;
    while (made < n) begin
      case ($urandom_range(3))
        0: begin
          x = ($urandom_range(1) == 0) ? $urandom_range(COLUMNS - 8, COLUMNS) :
                                         $urandom_range(1, COLUMNS);
          y = ($urandom_range(1) == 0) ? ROWS : $urandom_range(1, ROWS);
          len = $urandom_range(2, 16);
          queue_cmd(FUNC_GOTO_XY, $urandom, x, y);
          for (int i = 0; i < len; i++)
            queue_cmd(FUNC_PUT_CHAR, $urandom_range(32, 126), $urandom, $urandom);
          if ($urandom_range(1) == 0) begin
            queue_cmd(FUNC_PUT_CHAR, CHAR_CR, $urandom, $urandom);
            queue_cmd(FUNC_PUT_CHAR, CHAR_LF, $urandom, $urandom);
            made += 2;
          end
          made += len + 1;
        end
        1: begin
          x = $urandom_range(1, COLUMNS);
          y = $urandom_range(1, ROWS);
          queue_cmd(FUNC_GOTO_XY, $urandom, x, y);
          queue_cmd(FUNC_PUT_CHAR, $urandom, $urandom, $urandom);
          queue_cmd(FUNC_READ_CELL, $urandom, x, y);
          queue_cmd(FUNC_READ_CELL, $urandom, x + 1, y);
          made += 4;
        end
        default: begin
          pending_cmds.push_back(random_cmd());
          made++;
        end
      endcase
    end
  endtask

  initial begin
    // Reset is held from time zero and released once.
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    // The block blanks its store after reset with full held high.
    do @(negedge clk); while (full !== 1'b0);

    // Directed part with autowrap off.
    set_autowrap(1'b0);
    tx_idle <= 1'b1;
    rx_idle <= 1'b1;
    queue_cmd(FUNC_READ_CELL,    0, 1, 1);          // a fresh screen reads space
    queue_cmd(FUNC_PUT_CHAR,     8'h48, 0, 0);
    queue_cmd(FUNC_PUT_CHAR,     8'hFF, 255, 255);
    queue_cmd(FUNC_PUT_CHAR,     8'h00, 0, 0);
    queue_cmd(FUNC_READ_CELL,    0, 2, 1);
    queue_cmd(FUNC_PUT_CHAR,     CHAR_BS, 0, 0);    // erase the cell to the left
    queue_cmd(FUNC_PUT_CHAR,     CHAR_CR, 0, 0);
    queue_cmd(FUNC_PUT_CHAR,     CHAR_BS, 0, 0);    // backspace at column 0
    queue_cmd(FUNC_PUT_CHAR,     CHAR_LF, 0, 0);
    queue_cmd(FUNC_GOTO_XY,      0, COLUMNS, ROWS);
    queue_cmd(FUNC_PUT_CHAR,     8'h7E, 0, 0);      // last column, cursor parks
    queue_cmd(FUNC_PUT_CHAR,     8'h41, 0, 0);      // ignored while parked
    queue_cmd(FUNC_PUT_CHAR,     CHAR_BS, 0, 0);    // ignored while parked
    queue_cmd(FUNC_CLEAR_EOL,    0, 0, 0);          // clears nothing while parked
    queue_cmd(FUNC_READ_CELL,    0, COLUMNS, ROWS);
    queue_cmd(FUNC_GOTO_XY,      0, 0, 5);          // column axis out of range
    queue_cmd(FUNC_GOTO_XY,      0, COLUMNS + 1, 0);
    queue_cmd(FUNC_GOTO_XY,      0, 255, 255);
    queue_cmd(FUNC_GOTO_XY,      0, 1, ROWS);
    queue_cmd(FUNC_PUT_CHAR,     CHAR_LF, 0, 0);    // line feed on the bottom line
    queue_cmd(FUNC_READ_CELL,    0, COLUMNS, ROWS - 1);
    queue_cmd(FUNC_GOTO_XY,      0, 40, ROWS - 1);
    queue_cmd(FUNC_CLEAR_EOL,    0, 0, 0);
    queue_cmd(FUNC_READ_CELL,    0, 0, 0);
    queue_cmd(FUNC_READ_CELL,    0, COLUMNS + 1, ROWS);
    queue_cmd(FUNC_READ_CELL,    0, 1, ROWS + 1);
    queue_cmd(3'd5, 8'hAA, 8'h55, 8'hAA);
    queue_cmd(3'd6, 8'h55, 8'hAA, 8'h55);
    queue_cmd(3'd7, 8'hFF, 8'hFF, 8'hFF);
    queue_cmd(FUNC_CLEAR_SCREEN, 0, 0, 0);
    wait_drained();

    // Autowrap on: wrapping past the bottom line scrolls, elsewhere it does not.
    set_autowrap(1'b1);
    queue_cmd(FUNC_GOTO_XY,      0, COLUMNS - 1, ROWS);
    queue_cmd(FUNC_PUT_CHAR,     8'h61, 0, 0);
    queue_cmd(FUNC_PUT_CHAR,     8'h62, 0, 0);
    queue_cmd(FUNC_GOTO_XY,      0, COLUMNS, 1);
    queue_cmd(FUNC_PUT_CHAR,     8'h63, 0, 0);
    queue_cmd(FUNC_READ_CELL,    0, COLUMNS, 1);
    queue_random_phase(PHASE_ITEMS, 1'b1);
    wait_drained();

    // The long receiver hold-off falls in this phase.
    set_autowrap(1'b0);
    queue_random_phase(PHASE_ITEMS, 1'b1);
    wait_drained();

    // A phase that streams with no idling on either side.
    set_autowrap(1'b1);
    queue_random_phase(PHASE_ITEMS, 1'b0);
    wait_drained();

    set_autowrap(1'b0);
    queue_random_phase(PHASE_ITEMS, 1'b1);
    wait_drained();

    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/ttsb_pkg.sv
design/ttsb_ram.sv
design/ttsb_fifo.sv
design/ttsb_front.sv
design/ttsb_back.sv
design/text_terminal_screen_buffer.sv
verif/tb_top.sv
